FILE: hw/rtl/life_generation_engine_macros.svh
// Assertion macros shared by the checker of the life generation engine.
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life generation engine: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LGE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life generation engine: check failed");

`endif

FILE: hw/rtl/lge_pkg.sv
// Types, constants and the cell rule of the life generation engine.
package lge_pkg;

    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 6;
    localparam int NBR_W     = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_STEP  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // B3/S23: birth on three neighbours, survival on two or three.
    function automatic logic life_rule(input logic alive, input logic [NBR_W-1:0] n);
        return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
    endfunction

endpackage

FILE: hw/rtl/life_generation_engine.sv
// Life generation engine: a B3/S23 board in a row-wide two-bank memory.
//
// Requests arrive on the s_ channel, one result leaves on the m_ channel per request.
// A write or read inside the board reads its board row, and a write puts the row back
// with the cell changed; it passes through the access, modify and done states, and the
// result enters the output register as the block returns to idle, where the next request
// can be accepted. An out-of-range write or read, or an unknown request, goes from the
// access state straight to the done state. A step goes through the access, step and done
// states: the sweep reads one row of the current bank per cycle and writes each finished
// row, after the read data and middle window registers, into the other bank, covering
// all MAX_ROWS rows so that cells outside the board in use turn dead. Only one request
// is in progress at a time. The result sits in an output register, so a request is
// accepted while an earlier result still waits; that request then keeps its own result,
// and s_tready low, for every further cycle that m_tready stays low.
// After reset the current bank is cleared, one row per cycle, with s_tready low;
// configuration writes are taken at all times. Both size registers reset to 64 and
// may only be written while the block is idle.
module life_generation_engine
    import lge_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // req_type[1:0], row[7:2], col[13:8], cell_in[14]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // cell_out[0], out_of_range[1]
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int AW    = ROW_W + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int RC_W  = $clog2(MAX_ROWS + 3);
    localparam int RW    = (RC_W > SIZE_W) ? RC_W : SIZE_W;
    localparam int CC_W  = $clog2(MAX_COLS + 1);
    localparam int CW    = (CC_W > SIZE_W) ? CC_W : SIZE_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_MODIFY,
        S_STEP,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [SIZE_W-1:0]   rows_in_use_reg;
    logic [SIZE_W-1:0]   cols_in_use_reg;
    logic                cur_bank_reg;
    req_t                req_type_reg;
    logic [POS_W-1:0]    req_row_reg;
    logic [POS_W-1:0]    req_col_reg;
    logic                req_cell_reg;
    logic [RC_W-1:0]     cnt_reg;
    logic [MAX_COLS-1:0] win_above_reg;
    logic [MAX_COLS-1:0] win_mid_reg;
    logic [MAX_COLS-1:0] rdata_reg;
    logic                res_cell_reg;
    logic                res_oor_reg;
    logic                out_cell_reg;
    logic                out_oor_reg;
    logic                m_tvalid_reg;

    logic [MAX_COLS-1:0] board_mem [DEPTH];

    logic [RW-1:0]       eff_rows;
    logic [CW-1:0]       eff_cols;
    logic [MAX_COLS-1:0] col_mask;
    logic                req_oor;
    logic                req_cell_access;
    logic [ROW_W-1:0]    row_idx;
    logic [COL_W-1:0]    col_idx;
    logic                below_ok;
    logic                out_row_ok;
    logic [MAX_COLS-1:0] below_row;
    logic [MAX_COLS-1:0] keep_mask;
    logic [MAX_COLS-1:0] new_row;
    logic [MAX_COLS-1:0] mod_row;
    logic                out_free;
    logic                step_last;
    logic                clear_last;

    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'b0, out_oor_reg, out_cell_reg};

    // Sizes above the board maximum act as the maximum.
    assign eff_rows = (RW'(rows_in_use_reg) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS)
                                                              : RW'(rows_in_use_reg);
    assign eff_cols = (CW'(cols_in_use_reg) > CW'(MAX_COLS)) ? CW'(MAX_COLS)
                                                              : CW'(cols_in_use_reg);

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (CW'(c) < eff_cols);
        end
    end

    assign req_cell_access = (req_type_reg == REQ_WRITE) || (req_type_reg == REQ_READ);
    assign req_oor = (RW'(req_row_reg) >= eff_rows) || (CW'(req_col_reg) >= eff_cols);
    assign row_idx = ROW_W'(req_row_reg);
    assign col_idx = COL_W'(req_col_reg);

    always_comb
    begin
        mod_row          = rdata_reg;
        mod_row[col_idx] = req_cell_reg;
    end

    // During a step the read data holds row cnt-1 and the row being finished is cnt-2.
    assign below_ok   = (cnt_reg != '0) && (RW'(cnt_reg) <= eff_rows);
    assign out_row_ok = (RW'(cnt_reg) < (eff_rows + RW'(2)));
    assign below_row  = below_ok ? (rdata_reg & col_mask) : '0;
    assign keep_mask  = out_row_ok ? col_mask : '0;
    assign step_last  = (cnt_reg == RC_W'(MAX_ROWS + 1));
    assign clear_last = (cnt_reg == RC_W'(MAX_ROWS - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    lge_row_next #(
        .NCOLS(MAX_COLS)
    ) u_row_next (
        .above    (win_above_reg),
        .mid      (win_mid_reg),
        .below    (below_row),
        .keep     (keep_mask),
        .next_row (new_row)
    );

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = {cur_bank_reg, row_idx};
        mem_we    = 1'b0;
        mem_waddr = {cur_bank_reg, row_idx};
        mem_wdata = mod_row;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {1'b0, cnt_reg[ROW_W-1:0]};
                mem_wdata = '0;
            end
            S_ACCESS:
            begin
                mem_re = req_cell_access && !req_oor;
            end
            S_MODIFY:
            begin
                mem_we = (req_type_reg == REQ_WRITE);
            end
            S_STEP:
            begin
                mem_re    = (cnt_reg < RC_W'(MAX_ROWS));
                mem_raddr = {cur_bank_reg, cnt_reg[ROW_W-1:0]};
                mem_we    = (cnt_reg >= RC_W'(2));
                mem_waddr = {~cur_bank_reg, ROW_W'(cnt_reg - RC_W'(2))};
                mem_wdata = new_row;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            board_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= board_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            rows_in_use_reg <= SIZE_RESET;
            cols_in_use_reg <= SIZE_RESET;
            cur_bank_reg    <= 1'b0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ROWS: rows_in_use_reg <= cfg_data;
                    CFG_COLS: cols_in_use_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // In the result state the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + RC_W'(1);
                    if (clear_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_type_reg <= req_t'(s_tdata[1:0]);
                        req_row_reg  <= s_tdata[7:2];
                        req_col_reg  <= s_tdata[13:8];
                        req_cell_reg <= s_tdata[14];
                        state_reg    <= S_ACCESS;
                    end
                end
                S_ACCESS:
                begin
                    if (req_type_reg == REQ_STEP)
                    begin
                        cnt_reg       <= '0;
                        win_above_reg <= '0;
                        win_mid_reg   <= '0;
                        state_reg     <= S_STEP;
                    end
                    else if (req_cell_access && !req_oor)
                    begin
                        state_reg <= S_MODIFY;
                    end
                    else
                    begin
                        res_cell_reg <= 1'b0;
                        res_oor_reg  <= req_cell_access;
                        state_reg    <= S_DONE;
                    end
                end
                S_MODIFY:
                begin
                    res_cell_reg <= (req_type_reg == REQ_READ) ? rdata_reg[col_idx] : 1'b0;
                    res_oor_reg  <= 1'b0;
                    state_reg    <= S_DONE;
                end
                S_STEP:
                begin
                    cnt_reg <= cnt_reg + RC_W'(1);
                    if (cnt_reg != '0)
                    begin
                        win_above_reg <= win_mid_reg;
                        win_mid_reg   <= below_row;
                    end
                    if (step_last)
                    begin
                        cur_bank_reg <= ~cur_bank_reg;
                        res_cell_reg <= 1'b0;
                        res_oor_reg  <= 1'b0;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_cell_reg <= res_cell_reg;
                        out_oor_reg  <= res_oor_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/lge_row_next.sv
// Next-generation logic for one board row from the rows above, at and below it.
module lge_row_next
    import lge_pkg::*;
#(
    parameter int NCOLS = 64
)(
    input  logic [NCOLS-1:0] above,
    input  logic [NCOLS-1:0] mid,
    input  logic [NCOLS-1:0] below,
    input  logic [NCOLS-1:0] keep,
    output logic [NCOLS-1:0] next_row
);

    logic [NCOLS+1:0] above_pad;
    logic [NCOLS+1:0] mid_pad;
    logic [NCOLS+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign mid_pad   = {1'b0, mid, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // Every column counts its eight neighbours on its own; the board edges read as dead.
    always_comb
    begin
        logic [NBR_W-1:0] n;
        n = '0;
        for (int c = 0; c < NCOLS; c++)
        begin
            n = NBR_W'(above_pad[c]) + NBR_W'(above_pad[c+1]) + NBR_W'(above_pad[c+2])
              + NBR_W'(mid_pad[c]) + NBR_W'(mid_pad[c+2])
              + NBR_W'(below_pad[c]) + NBR_W'(below_pad[c+1]) + NBR_W'(below_pad[c+2]);
            next_row[c] = keep[c] & life_rule(mid[c], n);
        end
    end

endmodule

FILE: hw/rtl/lge_checker.sv
// Port-level checks of the life generation engine and their binding to the top level.
`include "life_generation_engine_macros.svh"

module lge_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result keeps its valid and its data.
    `LGE_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only one request is in progress, so ready drops after every transaction.
    `LGE_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A cell can only be returned by a read within the board.
    `LGE_ASSERT_IMP(a_cell_in_range, clk, rst_n, m_tvalid && m_tdata[0], !m_tdata[1])

    // The padding bits of the result stay zero.
    `LGE_ASSERT_IMP(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[7:2] == 6'b0)

endmodule

bind life_generation_engine lge_checker u_lge_checker (.*);

FILE: tb/life_generation_engine_tb.sv
// Self-checking testbench for the life generation engine: cell reads, writes and generation steps.
`timescale 1ns / 1ps

module life_generation_engine_tb;
    import lge_pkg::*;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int BOARD_SIZE = MAX_ROWS * MAX_COLS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        req_t       kind;
        logic [5:0] row;
        logic [5:0] col;
        logic       cell_in;
    } cell_request_t;

    typedef struct {
        logic cell_out;
        logic out_of_range;
    } cell_reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // req_type[1:0], row[7:2], col[13:8], cell_in[14]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // cell_out[0], out_of_range[1]

    // Board model: two banks of cells, the live one selected by live_bank.
    bit          board [2][BOARD_SIZE];
    bit          live_bank;
    int unsigned board_rows;
    int unsigned board_cols;

    cell_request_t request_fifo [$];
    cell_reply_t   awaited_replies [$];
    cell_request_t offered;
    bit            req_taken;

    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned replies_checked;
    int unsigned generations;
    int unsigned sizes_tried;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned ready_mode;
    int unsigned ready_left;
    int unsigned ready_tick;
    int unsigned hold_at;
    bit          hold_off;

    life_generation_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Applies one request to the board model and returns the reply it should produce.
    function automatic cell_reply_t apply_request(input cell_request_t rq);
        cell_reply_t reply;
        int          nr;
        int          nc;
        int          live;
        int          rr;
        int          cc;
        bit          src;
        bit          alive;
        reply.cell_out     = 1'b0;
        reply.out_of_range = 1'b0;
        nr = int'((board_rows > MAX_ROWS) ? MAX_ROWS : board_rows);
        nc = int'((board_cols > MAX_COLS) ? MAX_COLS : board_cols);
        case (rq.kind)
            REQ_WRITE, REQ_READ:
            begin
                if (rq.row >= nr || rq.col >= nc)
                    reply.out_of_range = 1'b1;
                else if (rq.kind == REQ_WRITE)
                    board[live_bank][rq.row * MAX_COLS + rq.col] = rq.cell_in;
                else
                    reply.cell_out = board[live_bank][rq.row * MAX_COLS + rq.col];
            end
            REQ_STEP:
            begin
                src = live_bank;
                for (int i = 0; i < BOARD_SIZE; i++)
                    board[!src][i] = 1'b0;
                for (int r = 0; r < nr; r++)
                begin
                    for (int c = 0; c < nc; c++)
                    begin
                        live = 0;
                        for (int dr = -1; dr <= 1; dr++)
                        begin
                            for (int dc = -1; dc <= 1; dc++)
                            begin
                                rr = r + dr;
                                cc = c + dc;
                                if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
                                    rr < nr && cc < nc)
                                    live += board[src][rr * MAX_COLS + cc];
                            end
                        end
                        alive = board[src][r * MAX_COLS + c];
                        board[!src][r * MAX_COLS + c] =
                            (live == 3) || (alive && live == 2);
                    end
                end
                live_bank = !src;
                generations++;
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    task automatic queue_request(input req_t kind, input int row, input int col,
                                 input bit cell_in);
        cell_request_t rq;
        rq.kind    = kind;
        rq.row     = row[5:0];
        rq.col     = col[5:0];
        rq.cell_in = cell_in;
        request_fifo.push_back(rq);
        items_queued++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ROWS: board_rows = 32'(value);
            CFG_COLS: board_cols = 32'(value);
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic resize_board(input int rows, input int cols);
        write_register(CFG_ROWS, rows[SIZE_W-1:0]);
        write_register(CFG_COLS, cols[SIZE_W-1:0]);
        sizes_tried++;
    endtask

    // Waits until every queued request has been answered, then lets a few idle
    // cycles pass before the sizes change.
    task automatic wait_idle();
        while (!(items_taken == items_queued && awaited_replies.size() == 0))
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Mostly writes and reads inside a small window so that steps give a living pattern;
    // the rest are steps, idle requests and coordinates anywhere, possibly outside the board.
    task automatic random_requests(input int count);
        int nr;
        int nc;
        int base_r;
        int base_c;
        int pick;
        int r;
        int c;
        nr = int'((board_rows > MAX_ROWS) ? MAX_ROWS : board_rows);
        nc = int'((board_cols > MAX_COLS) ? MAX_COLS : board_cols);
        base_r = (nr > 8) ? $urandom_range(0, nr - 8) : 0;
        base_c = (nc > 8) ? $urandom_range(0, nc - 8) : 0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (nr == 0 || nc == 0 || $urandom_range(0, 7) == 0)
            begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
            end
            else
            begin
                r = (nr > 8) ? base_r + $urandom_range(0, 7) : $urandom_range(0, nr - 1);
                c = (nc > 8) ? base_c + $urandom_range(0, 7) : $urandom_range(0, nc - 1);
            end
            if (pick < 40)
                queue_request(REQ_WRITE, r, c, $urandom_range(0, 3) != 0);
            else if (pick < 52)
                queue_request(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 1) != 0);
            else if (pick < 85)
                queue_request(REQ_READ, r, c, $urandom_range(0, 1) != 0);
            else if (pick < 95)
                queue_request($urandom_range(0, 1) ? REQ_READ : REQ_WRITE,
                              $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 1) != 0);
            else
                queue_request(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 1) != 0);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        live_bank  = 1'b0;
        board_rows = 32'(SIZE_RESET);
        board_cols = 32'(SIZE_RESET);
        hold_at    = 32'hFFFF_FFFF;
        sizes_tried = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corners of the full board, then a blinker through two generations.
        queue_request(REQ_WRITE, 0, 0, 1'b1);
        queue_request(REQ_READ, 0, 0, 1'b0);
        queue_request(REQ_WRITE, 63, 63, 1'b1);
        queue_request(REQ_READ, 63, 63, 1'b0);
        queue_request(REQ_WRITE, 10, 10, 1'b1);
        queue_request(REQ_WRITE, 10, 11, 1'b1);
        queue_request(REQ_WRITE, 10, 12, 1'b1);
        queue_request(REQ_STEP, 0, 0, 1'b0);
        queue_request(REQ_READ, 9, 11, 1'b0);
        queue_request(REQ_READ, 10, 10, 1'b0);
        queue_request(REQ_READ, 11, 11, 1'b0);
        queue_request(REQ_STEP, 63, 63, 1'b1);
        queue_request(REQ_READ, 10, 12, 1'b0);
        queue_request(REQ_NONE, 63, 63, 1'b1);
        wait_idle();

        // A small board: edges out of range, and the blinker outside it dies at a step.
        resize_board(5, 7);
        queue_request(REQ_WRITE, 5, 0, 1'b1);
        queue_request(REQ_READ, 0, 7, 1'b0);
        queue_request(REQ_WRITE, 4, 6, 1'b1);
        queue_request(REQ_READ, 4, 6, 1'b0);
        queue_request(REQ_STEP, 0, 0, 1'b0);
        wait_idle();

        // An empty board: everything is out of range and a step clears the new bank.
        resize_board(0, 7);
        queue_request(REQ_READ, 0, 0, 1'b0);
        queue_request(REQ_WRITE, 0, 0, 1'b1);
        queue_request(REQ_STEP, 0, 0, 1'b0);
        wait_idle();

        // Sizes above the maximum act as the maximum; unknown indexes change nothing.
        resize_board(100, 127);
        write_register(2'd2, 7'd0);
        write_register(2'd3, 7'd127);
        queue_request(REQ_READ, 10, 11, 1'b0);
        queue_request(REQ_READ, 63, 63, 1'b0);
        wait_idle();

        resize_board(64, 64);
        hold_at = items_taken + 8;
        random_requests(25);
        wait_idle();

        resize_board(8, 8);
        random_requests(25);
        wait_idle();

        resize_board($urandom_range(1, 64), $urandom_range(1, 64));
        random_requests(25);
        wait_idle();

        resize_board(1, 64);
        random_requests(15);
        wait_idle();

        resize_board(64, 3);
        random_requests(25);
        wait_idle();

        if (awaited_replies.size() != 0)
        begin
            $error("%0d replies never arrived", awaited_replies.size());
            mismatches++;
        end
        $display("Run covered %0d requests, %0d generation steps, %0d board sizes.",
                 items_taken, generations, sizes_tried);
        $display("%0d replies were checked against the board model.", replies_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : drive_requests
        logic        nxt_valid;
        logic [15:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (!rst_n)
            nxt_valid = 1'b0;
        else
        begin
            if (req_taken)
            begin
                nxt_valid = 1'b0;
                req_taken = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_fifo.size() > 0)
                begin
                    offered   = request_fifo.pop_front();
                    nxt_data  = {1'b0, offered.cell_in, offered.col, offered.row,
                                 offered.kind};
                    nxt_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            awaited_replies.push_back(apply_request(offered));
            items_taken++;
            req_taken = 1'b1;
        end
    end

    // Reply receiver: the stall pattern changes every so often, and is overridden
    // by the long hold-off.
    always @(negedge clk)
    begin : drive_ready
        logic rdy;
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end
        else
            ready_left--;
        ready_tick++;
        case (ready_mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 1) != 0);
            2:       rdy = (ready_tick % 3 == 0);
            default: rdy = ($urandom_range(0, 7) != 0);
        endcase
        m_tready <= rdy && !hold_off && rst_n;
    end

    // Long hold-off on the reply side while requests keep coming, so the input backs up.
    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        while (items_taken < hold_at)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin : check_replies
        cell_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply with no request outstanding: tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (m_tdata[0] !== want.cell_out)
                begin
                    $error("cell_out: expected %0b, got %0b", want.cell_out, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0b, got %0b",
                           want.out_of_range, m_tdata[1]);
                    mismatches++;
                end
                replies_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lge_pkg.sv
hw/rtl/lge_row_next.sv
hw/rtl/life_generation_engine.sv
hw/rtl/lge_checker.sv
tb/life_generation_engine_tb.sv
